[rtl/core/dq_pkg.sv]
// dq_pkg: shared types and constants for the double-ended queue core
// action and status codes, default capacity and field widths
// no dependencies
package dq_pkg;

  localparam int DQ_CAPACITY = 16;
  localparam int DATA_W = 32;
  localparam int ACT_W = 3;
  localparam int STAT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_REAR  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_REAR  = 3'd3,
    ACT_DISPLAY   = 3'd4
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DELETED    = 3'd0,
    ST_DISP_ENTRY = 3'd1,
    ST_EMPTY_DEL  = 3'd2,
    ST_EMPTY_DISP = 3'd3,
    ST_FULL       = 3'd4
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STAT = 4'b0010,
    S_RD   = 4'b0100,
    S_RDW  = 4'b1000
  } state_t;

endpackage

[rtl/core/dq_ram.sv]
// dq_ram: generic single-port synchronous ram with registered read
// width and depth set by parameters
// no dependencies
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/double_ended_queue_core.sv]
// double_ended_queue_core: bounded deque of signed 32-bit words in a ring ram
// depends on dq_pkg and dq_ram
//
// Input channel s_*: one word per request; s_tuser carries the action code and
// s_tdata the value to insert. Output channel m_*: result words with the
// removed or displayed value in m_tdata, the status code in m_tuser and m_tlast
// on the final result of a request.
// An insert that fits writes the ring ram in its accept cycle and gives no
// result; s_tready stays high, so inserts go at one per cycle.
// A delete issues its ram read in S_RD once the output register is free and
// loads the result in S_RDW; s_tready returns high in the cycle it is valid.
// Status-only results (full, empty) pass through S_STAT into the output register.
// A display emits one word per read-then-load turn (S_RD, then S_RDW) of the
// single ram port, and holds s_tready low until the rear entry is loaded.
// The output register parts the two sides: when m_tready is low the result
// waits there, reads are not issued until it frees, and inserts are still
// taken while the block is idle.
// Reset clears the front pointer, the occupancy and the output valid; ram
// contents are left as they are, since only occupied entries are ever read.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int CAPACITY = DQ_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [DATA_W-1:0] s_tdata,  // value
  input  logic [ACT_W-1:0]         s_tuser,  // action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic signed [DATA_W-1:0] m_tdata,  // item
  output logic [STAT_W-1:0]        m_tuser,  // status
  output logic                     m_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int SW = OW + 1;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [IW-1:0] IDX_MAX = IW'(CAPACITY - 1);

  state_t state, state_next;
  logic [IW-1:0] front, front_next;
  logic [OW-1:0] occ, occ_next;
  logic [IW-1:0] addr, addr_next;
  logic [OW-1:0] left, left_next;
  logic disp, disp_next;
  stat_t stat_code, stat_code_next;
  logic m_tvalid_next;
  logic signed [DATA_W-1:0] m_tdata_next;
  logic [STAT_W-1:0] m_tuser_next;
  logic m_tlast_next;

  logic ram_we, ram_re;
  logic [IW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  logic accept, out_free, full, empty;
  act_t act;
  logic [SW-1:0] sum_rear, sum_last;
  logic [IW-1:0] idx_rear, idx_last, front_dec, front_inc, addr_inc;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign act = act_t'(s_tuser);
  assign full = (occ == OW'(CAPACITY));
  assign empty = (occ == '0);

  assign sum_rear = SW'(front) + SW'(occ);
  assign sum_last = sum_rear - SW'(1);
  assign idx_rear = (sum_rear >= CAP_S) ? IW'(sum_rear - CAP_S) : IW'(sum_rear);
  assign idx_last = (sum_last >= CAP_S) ? IW'(sum_last - CAP_S) : IW'(sum_last);
  assign front_dec = (front == '0) ? IDX_MAX : front - IW'(1);
  assign front_inc = (front == IDX_MAX) ? '0 : front + IW'(1);
  assign addr_inc = (addr == IDX_MAX) ? '0 : addr + IW'(1);

  dq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(s_tdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    front_next = front;
    occ_next = occ;
    addr_next = addr;
    left_next = left;
    disp_next = disp;
    stat_code_next = stat_code;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next = m_tdata;
    m_tuser_next = m_tuser;
    m_tlast_next = m_tlast;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr = addr;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (act) inside
            ACT_INS_FRONT, ACT_INS_REAR: begin
              if (full) begin
                stat_code_next = ST_FULL;
                state_next = S_STAT;
              end else begin
                ram_we = 1'b1;
                occ_next = occ + OW'(1);
                if (act == ACT_INS_FRONT) begin
                  ram_addr = front_dec;
                  front_next = front_dec;
                end else begin
                  ram_addr = idx_rear;
                end
              end
            end
            ACT_DEL_FRONT, ACT_DEL_REAR: begin
              if (empty) begin
                stat_code_next = ST_EMPTY_DEL;
                state_next = S_STAT;
              end else begin
                disp_next = 1'b0;
                occ_next = occ - OW'(1);
                if (act == ACT_DEL_FRONT) begin
                  addr_next = front;
                  front_next = front_inc;
                end else begin
                  addr_next = idx_last;
                end
                state_next = S_RD;
              end
            end
            ACT_DISPLAY: begin
              if (empty) begin
                stat_code_next = ST_EMPTY_DISP;
                state_next = S_STAT;
              end else begin
                disp_next = 1'b1;
                addr_next = front;
                left_next = occ;
                state_next = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next = '0;
          m_tuser_next = stat_code;
          m_tlast_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          ram_re = 1'b1;
          state_next = S_RDW;
        end
      end
      S_RDW: begin
        m_tvalid_next = 1'b1;
        m_tdata_next = ram_rdata;
        m_tuser_next = disp ? ST_DISP_ENTRY : ST_DELETED;
        m_tlast_next = !disp || (left == OW'(1));
        if (disp && (left != OW'(1))) begin
          left_next = left - OW'(1);
          addr_next = addr_inc;
          state_next = S_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      occ <= occ_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    left <= left_next;
    disp <= disp_next;
    stat_code <= stat_code_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

  a_rdw_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDW) |-> !m_tvalid)
    else $error("read data returned while output register busy");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    (occ <= OW'(CAPACITY)) && (SW'(front) < CAP_S))
    else $error("occupancy or front pointer out of range");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (act == ACT_INS_FRONT || act == ACT_INS_REAR))
      |=> (occ == $past(occ) + OW'(1)))
    else $error("insert did not grow occupancy");

endmodule
